### hw/rtl/dsdcd_pkg.sv
package dsdcd_pkg;

    localparam int unsigned MAX_CHANNELS = 8;
    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QPTR_W       = $clog2(QDEPTH);
    localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [31:0] ID_FRM8 = 32'h4652_4D38;
    localparam logic [31:0] ID_DSD  = 32'h4453_4420;
    localparam logic [31:0] ID_PROP = 32'h5052_4F50;
    localparam logic [31:0] ID_SND  = 32'h534E_4420;
    localparam logic [31:0] ID_FS   = 32'h4653_2020;
    localparam logic [31:0] ID_CHNL = 32'h4348_4E4C;
    localparam logic [31:0] ID_CMPR = 32'h434D_5052;

    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_FORM       = 3'd0;
    localparam logic [2:0] ERR_MALFORMED  = 3'd1;
    localparam logic [2:0] ERR_COMPRESSED = 3'd2;
    localparam logic [2:0] ERR_FORMAT     = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic       final_byte;
    } t_dsdcd_in;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  audio_byte;
        logic [2:0]  error_code;
        logic [31:0] dsd_rate;
        logic [3:0]  channel_count;
        logic [63:0] audio_bytes;
        logic        last_of_run;
    } t_dsdcd_out;

    typedef struct packed {
        logic [1:0]            cnt;
        t_dsdcd_out [1:0]      res;
    } t_dsdcd_entry;

    function automatic t_dsdcd_out dsdcd_err(input logic [2:0] code);
        t_dsdcd_out r;
        r             = '0;
        r.out_kind    = KIND_ERROR;
        r.error_code  = code;
        r.last_of_run = 1'b1;
        return r;
    endfunction

endpackage

### hw/rtl/dsdcd_front.sv
module dsdcd_front
    import dsdcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_dsdcd_in    i_word,
    input  logic         i_lsb_first,
    output logic         o_push,
    output t_dsdcd_entry o_entry
);

    typedef enum logic [3:0] {
        PH_FORM, PH_TOP_HDR, PH_TOP_SKIP, PH_PROP_ID, PH_PROP_SKIP, PH_SND_HDR,
        PH_FS, PH_CHNL, PH_CMPR, PH_SND_SKIP, PH_AUDIO, PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_fc, n_fc;
    logic [31:0] r_id, n_id;
    logic [63:0] r_size, n_size;
    logic [63:0] r_prop, n_prop;
    logic [63:0] r_chunk, n_chunk;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_chan, n_chan;
    logic [63:0] r_audio, n_audio;
    logic [4:0]  r_fpos, n_fpos;

    logic        p_valid, f_valid;
    t_dsdcd_out  p_res;
    logic [63:0] padded;
    logic [7:0]  ob;
    logic        hdr_done;

    always_comb begin
        n_phase = r_phase; n_fc = r_fc; n_id = r_id; n_size = r_size;
        n_prop = r_prop; n_chunk = r_chunk; n_rate = r_rate; n_chan = r_chan;
        n_audio = r_audio; n_fpos = r_fpos;
        p_valid = 1'b0; f_valid = 1'b0; p_res = '0; padded = '0; hdr_done = 1'b0;
        for (int i = 0; i < 8; i++) ob[7 - i] = i_word.file_byte[i];
        if (!i_lsb_first) ob = i_word.file_byte;
        if (i_accept) begin
            if (i_word.first_byte) begin
                n_phase = PH_FORM; n_fc = '0; n_id = '0; n_size = '0; n_prop = '0;
                n_chunk = '0; n_rate = '0; n_chan = '0; n_audio = '0; n_fpos = '0;
            end
            if (n_phase != PH_IDLE) begin
                unique case (n_phase)
                    PH_FORM: begin
                        if (n_fc < 5'd4 || n_fc >= 5'd12) n_id = {n_id[23:0], i_word.file_byte};
                        else n_size = {n_size[55:0], i_word.file_byte};
                        n_fc = n_fc + 5'd1;
                        if (n_fc == 5'd4 && n_id != ID_FRM8) begin
                            p_valid = 1'b1; p_res = dsdcd_err(ERR_FORM); n_phase = PH_IDLE;
                        end else if (n_fc >= 5'd16) begin
                            if (n_id != ID_DSD) begin
                                p_valid = 1'b1; p_res = dsdcd_err(ERR_FORM); n_phase = PH_IDLE;
                            end else begin
                                n_fc = '0; n_phase = PH_TOP_HDR;
                            end
                        end
                    end
                    PH_TOP_HDR, PH_SND_HDR: begin
                        if (n_phase == PH_SND_HDR) n_prop = n_prop - 64'd1;
                        if (n_fc < 5'd4) n_id = {n_id[23:0], i_word.file_byte};
                        else n_size = {n_size[55:0], i_word.file_byte};
                        n_fc = n_fc + 5'd1;
                        hdr_done = (n_fc >= 5'd12);
                        if (hdr_done && n_phase == PH_TOP_HDR) begin
                            n_fc = '0;
                            if (n_id == ID_PROP) begin
                                if (n_size < 64'd4) begin
                                    p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_prop = n_size; n_phase = PH_PROP_ID;
                                end
                            end else if (n_id == ID_DSD) begin
                                if (n_chan < 16'd1 || n_chan > 16'(MAX_CHANNELS)
                                    || n_rate < 32'd8) begin
                                    p_valid = 1'b1; p_res = dsdcd_err(ERR_FORMAT);
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_audio = n_size; n_fpos = '0;
                                    p_valid = 1'b1;
                                    p_res.out_kind = KIND_FORMAT;
                                    p_res.dsd_rate = n_rate;
                                    p_res.channel_count = n_chan[3:0];
                                    p_res.audio_bytes = n_size;
                                    if (n_size < {48'd0, n_chan}) begin
                                        p_res.last_of_run = 1'b1; n_phase = PH_IDLE;
                                    end else begin
                                        n_phase = PH_AUDIO;
                                    end
                                end
                            end else begin
                                n_chunk = n_size;
                                n_phase = (n_size == '0) ? PH_TOP_HDR : PH_TOP_SKIP;
                            end
                        end else if (hdr_done) begin
                            n_fc = '0;
                            padded = (n_size + 64'd1) & ~64'd1;
                            if (n_size == '1 || padded > n_prop) begin
                                p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                n_phase = PH_IDLE;
                            end else begin
                                n_chunk = padded;
                                if (n_id == ID_FS) begin
                                    n_phase = PH_FS;
                                    if (n_size != 64'd4) begin
                                        p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                        n_phase = PH_IDLE;
                                    end
                                end else if (n_id == ID_CHNL) begin
                                    n_phase = PH_CHNL;
                                    if (n_size < 64'd2) begin
                                        p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                        n_phase = PH_IDLE;
                                    end
                                end else if (n_id == ID_CMPR) begin
                                    n_phase = PH_CMPR;
                                    if (n_size < 64'd4) begin
                                        p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                        n_phase = PH_IDLE;
                                    end
                                end else if (padded == '0) begin
                                    if (n_prop == '0) n_phase = PH_TOP_HDR;
                                    else if (n_prop < 64'd12) begin
                                        p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                        n_phase = PH_IDLE;
                                    end else n_phase = PH_SND_HDR;
                                end else begin
                                    n_phase = PH_SND_SKIP;
                                end
                            end
                        end
                    end
                    PH_TOP_SKIP: begin
                        n_chunk = n_chunk - 64'd1;
                        if (n_chunk == '0) begin
                            n_fc = '0; n_phase = PH_TOP_HDR;
                        end
                    end
                    PH_PROP_ID: begin
                        n_id = {n_id[23:0], i_word.file_byte};
                        n_prop = n_prop - 64'd1;
                        n_fc = n_fc + 5'd1;
                        if (n_fc >= 5'd4) begin
                            n_fc = '0;
                            if (n_id == ID_SND) begin
                                if (n_prop == '0) n_phase = PH_TOP_HDR;
                                else if (n_prop < 64'd12) begin
                                    p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                    n_phase = PH_IDLE;
                                end else n_phase = PH_SND_HDR;
                            end else begin
                                n_phase = (n_prop == '0) ? PH_TOP_HDR : PH_PROP_SKIP;
                            end
                        end
                    end
                    PH_PROP_SKIP: begin
                        n_prop = n_prop - 64'd1;
                        if (n_prop == '0) begin
                            n_fc = '0; n_phase = PH_TOP_HDR;
                        end
                    end
                    PH_FS, PH_CHNL, PH_CMPR, PH_SND_SKIP: begin
                        n_prop = n_prop - 64'd1;
                        n_chunk = n_chunk - 64'd1;
                        if (n_phase == PH_FS) begin
                            n_rate = {n_rate[23:0], i_word.file_byte};
                        end else if (n_phase == PH_CHNL) begin
                            if (n_fc < 5'd2) n_chan = {n_chan[7:0], i_word.file_byte};
                        end else if (n_phase == PH_CMPR && n_fc < 5'd4) begin
                            n_id = {n_id[23:0], i_word.file_byte};
                            if (n_fc == 5'd3 && n_id != ID_DSD) begin
                                p_valid = 1'b1; p_res = dsdcd_err(ERR_COMPRESSED);
                                n_phase = PH_IDLE;
                            end
                        end
                        if (!p_valid) begin
                            if (n_fc < 5'd15) n_fc = n_fc + 5'd1;
                            if (n_chunk == '0) begin
                                n_fc = '0;
                                if (n_prop == '0) n_phase = PH_TOP_HDR;
                                else if (n_prop < 64'd12) begin
                                    p_valid = 1'b1; p_res = dsdcd_err(ERR_MALFORMED);
                                    n_phase = PH_IDLE;
                                end else n_phase = PH_SND_HDR;
                            end
                        end
                    end
                    PH_AUDIO: begin
                        n_audio = n_audio - 64'd1;
                        n_fpos = n_fpos + 5'd1;
                        p_valid = 1'b1;
                        p_res.out_kind = KIND_AUDIO;
                        p_res.audio_byte = ob;
                        if ({11'd0, n_fpos} >= n_chan) begin
                            n_fpos = '0;
                            if (n_audio < {48'd0, n_chan}) begin
                                p_res.last_of_run = 1'b1; n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
                if (i_word.final_byte) begin
                    if (n_phase != PH_IDLE) f_valid = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_comb begin
        o_entry = '0;
        if (p_valid) begin
            o_entry.res[0] = p_res;
            o_entry.res[1] = dsdcd_err(ERR_TRUNCATED);
            o_entry.cnt    = f_valid ? 2'd2 : 2'd1;
        end else begin
            o_entry.res[0] = dsdcd_err(ERR_TRUNCATED);
            o_entry.cnt    = {1'b0, f_valid};
        end
        o_push = i_accept && (p_valid || f_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FORM; r_fc <= '0; r_id <= '0; r_size <= '0; r_prop <= '0;
            r_chunk <= '0; r_rate <= '0; r_chan <= '0; r_audio <= '0; r_fpos <= '0;
        end else begin
            r_phase <= n_phase; r_fc <= n_fc; r_id <= n_id; r_size <= n_size;
            r_prop <= n_prop; r_chunk <= n_chunk; r_rate <= n_rate; r_chan <= n_chan;
            r_audio <= n_audio; r_fpos <= n_fpos;
        end
    end

endmodule

### hw/rtl/dsdcd_queue.sv
module dsdcd_queue
    import dsdcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_dsdcd_entry i_entry,
    input  logic         i_pop,
    output t_dsdcd_entry o_head,
    output logic         o_empty,
    output logic         o_full
);

    t_dsdcd_entry        r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop) r_rd <= r_rd + QPTR_W'(1);
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + QCNT_W'($past(i_push))
                 - QCNT_W'($past(i_pop))) else $error("queue count drift");

endmodule

### hw/rtl/dsdcd_back.sv
module dsdcd_back
    import dsdcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dsdcd_entry i_head,
    input  logic         i_empty,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_dsdcd_out   o_out_word
);

    logic       r_valid;
    logic       r_sel;
    t_dsdcd_out r_word;
    logic       load;

    assign load        = !r_valid || !i_out_stall;
    assign o_pop       = load && !i_empty && (r_sel || i_head.cnt == 2'd1);
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_sel <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) r_sel <= !o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) r_word <= i_head.res[r_sel];
    end

endmodule

### hw/rtl/dsd_container_deframer.sv
// Path: each result word is held in the result queue (four entries), then in the output register.
// Throughput: one file word per cycle while the result queue is not full; a word that yields
// two results drains one result at a time from the queue into the output register.
// Reset: synchronous, active low; parser returns to the form header, lsb_first clears.
module dsd_container_deframer
    import dsdcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dsdcd_in  i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dsdcd_out o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic         r_lsb_first;
    logic         accept, push, pop, empty, full;
    t_dsdcd_entry entry, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lsb_first <= 1'b0;
        else if (i_cfg_valid && o_cfg_ready) r_lsb_first <= i_cfg_data;
    end

    dsdcd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_word(i_in_word),
        .i_lsb_first(r_lsb_first), .o_push(push), .o_entry(entry)
    );

    dsdcd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_entry(entry),
        .i_pop(pop), .o_head(head), .o_empty(empty), .o_full(full)
    );

    dsdcd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_empty(empty), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

endmodule

### test/dsd_container_deframer_tb.sv
module dsd_container_deframer_tb;
    import dsdcd_pkg::*;

    typedef enum int {
        P_FORM, P_TOP_HDR, P_TOP_SKIP, P_PROP_ID, P_PROP_SKIP, P_SND_HDR,
        P_FS, P_CHNL, P_CMPR, P_SND_SKIP, P_AUDIO, P_IDLE
    } t_phase;

    class dff_scoreboard;
        t_dsdcd_out  expected_q[$];
        int          errors;
        logic        lsb_first;
        t_phase      phase;
        int          fcount;
        int          nres;
        logic [31:0] id_sr;
        logic [63:0] size_sr;
        logic [63:0] prop_left;
        logic [63:0] chunk_left;
        logic [31:0] rate;
        logic [31:0] chans;
        logic [63:0] audio_left;
        int          frame_pos;

        function new();
            errors    = 0;
            nres      = 0;
            lsb_first = 1'b0;
            clear();
        endfunction

        function void clear();
            phase      = P_FORM;
            fcount     = 0;
            id_sr      = '0;
            size_sr    = '0;
            prop_left  = '0;
            chunk_left = '0;
            rate       = '0;
            chans      = '0;
            audio_left = '0;
            frame_pos  = 0;
        endfunction

        function void push(logic [1:0] kind, logic [7:0] ab, logic [2:0] code,
                           logic [31:0] sr, logic [3:0] cc, logic [63:0] nb, logic last);
            t_dsdcd_out r;
            if (nres >= 2) return;
            r.out_kind      = kind;
            r.audio_byte    = ab;
            r.error_code    = code;
            r.dsd_rate      = sr;
            r.channel_count = cc;
            r.audio_bytes   = nb;
            r.last_of_run   = last;
            expected_q.push_back(r);
            nres++;
        endfunction

        function void fail(logic [2:0] code);
            push(KIND_ERROR, 8'd0, code, 32'd0, 4'd0, 64'd0, 1'b1);
            phase = P_IDLE;
        endfunction

        function void snd_next();
            fcount = 0;
            if (prop_left == 0) phase = P_TOP_HDR;
            else if (prop_left < 12) fail(ERR_MALFORMED);
            else phase = P_SND_HDR;
        endfunction

        function bit hdr_byte(logic [7:0] b);
            if (fcount < 4) id_sr = {id_sr[23:0], b};
            else size_sr = {size_sr[55:0], b};
            fcount++;
            return fcount >= 12;
        endfunction

        function void top_done();
            fcount = 0;
            if (id_sr == ID_PROP) begin
                if (size_sr < 4) begin
                    fail(ERR_MALFORMED);
                    return;
                end
                prop_left = size_sr;
                phase     = P_PROP_ID;
            end else if (id_sr == ID_DSD) begin
                if (chans < 1 || chans > MAX_CHANNELS || rate < 8) begin
                    fail(ERR_FORMAT);
                    return;
                end
                audio_left = size_sr;
                frame_pos  = 0;
                if (size_sr < chans) begin
                    push(KIND_FORMAT, 8'd0, 3'd0, rate, chans[3:0], size_sr, 1'b1);
                    phase = P_IDLE;
                end else begin
                    push(KIND_FORMAT, 8'd0, 3'd0, rate, chans[3:0], size_sr, 1'b0);
                    phase = P_AUDIO;
                end
            end else begin
                chunk_left = size_sr;
                phase      = (size_sr == 0) ? P_TOP_HDR : P_TOP_SKIP;
            end
        endfunction

        function void snd_done();
            logic [63:0] padded;
            fcount = 0;
            if (size_sr == '1) begin
                fail(ERR_MALFORMED);
                return;
            end
            padded = (size_sr + 64'd1) & ~64'd1;
            if (padded > prop_left) begin
                fail(ERR_MALFORMED);
                return;
            end
            chunk_left = padded;
            if (id_sr == ID_FS) begin
                if (size_sr != 4) fail(ERR_MALFORMED);
                else phase = P_FS;
            end else if (id_sr == ID_CHNL) begin
                if (size_sr < 2) fail(ERR_MALFORMED);
                else phase = P_CHNL;
            end else if (id_sr == ID_CMPR) begin
                if (size_sr < 4) fail(ERR_MALFORMED);
                else phase = P_CMPR;
            end else if (padded == 0) begin
                snd_next();
            end else begin
                phase = P_SND_SKIP;
            end
        endfunction

        function void parse(logic [7:0] b);
            logic [7:0] ob;
            logic       last;
            case (phase)
                P_FORM: begin
                    if (fcount < 4 || fcount >= 12) id_sr = {id_sr[23:0], b};
                    else size_sr = {size_sr[55:0], b};
                    fcount++;
                    if (fcount == 4 && id_sr != ID_FRM8) begin
                        fail(ERR_FORM);
                        return;
                    end
                    if (fcount >= 16) begin
                        if (id_sr != ID_DSD) begin
                            fail(ERR_FORM);
                            return;
                        end
                        fcount = 0;
                        phase  = P_TOP_HDR;
                    end
                end
                P_TOP_HDR: begin
                    if (hdr_byte(b)) top_done();
                end
                P_TOP_SKIP: begin
                    chunk_left--;
                    if (chunk_left == 0) begin
                        fcount = 0;
                        phase  = P_TOP_HDR;
                    end
                end
                P_PROP_ID: begin
                    id_sr = {id_sr[23:0], b};
                    prop_left--;
                    fcount++;
                    if (fcount >= 4) begin
                        fcount = 0;
                        if (id_sr == ID_SND) snd_next();
                        else phase = (prop_left == 0) ? P_TOP_HDR : P_PROP_SKIP;
                    end
                end
                P_PROP_SKIP: begin
                    prop_left--;
                    if (prop_left == 0) begin
                        fcount = 0;
                        phase  = P_TOP_HDR;
                    end
                end
                P_SND_HDR: begin
                    prop_left--;
                    if (hdr_byte(b)) snd_done();
                end
                P_FS, P_CHNL, P_CMPR, P_SND_SKIP: begin
                    prop_left--;
                    chunk_left--;
                    if (phase == P_FS) begin
                        rate = {rate[23:0], b};
                    end else if (phase == P_CHNL) begin
                        if (fcount < 2) chans = {16'd0, chans[7:0], b};
                    end else if (phase == P_CMPR) begin
                        if (fcount < 4) begin
                            id_sr = {id_sr[23:0], b};
                            if (fcount == 3 && id_sr != ID_DSD) begin
                                fail(ERR_COMPRESSED);
                                return;
                            end
                        end
                    end
                    if (fcount < 15) fcount++;
                    if (chunk_left == 0) snd_next();
                end
                P_AUDIO: begin
                    ob   = lsb_first ? {<<{b}} : b;
                    last = 1'b0;
                    audio_left--;
                    frame_pos++;
                    if (frame_pos >= chans) begin
                        frame_pos = 0;
                        if (audio_left < chans) begin
                            last  = 1'b1;
                            phase = P_IDLE;
                        end
                    end
                    push(KIND_AUDIO, ob, 3'd0, 32'd0, 4'd0, 64'd0, last);
                end
                default: phase = P_IDLE;
            endcase
        endfunction

        function void note_word(t_dsdcd_in w);
            nres = 0;
            if (w.first_byte) clear();
            if (phase == P_IDLE) return;
            parse(w.file_byte);
            if (w.final_byte) begin
                if (phase != P_IDLE) fail(ERR_TRUNCATED);
                phase = P_IDLE;
            end
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_word(t_dsdcd_out a);
            t_dsdcd_out e;
            if (expected_q.size() == 0) begin
                $error("unexpected result word %0h", a);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("out_kind", e.out_kind, a.out_kind);
            cmp("audio_byte", e.audio_byte, a.audio_byte);
            cmp("error_code", e.error_code, a.error_code);
            cmp("dsd_rate", e.dsd_rate, a.dsd_rate);
            cmp("channel_count", e.channel_count, a.channel_count);
            cmp("audio_bytes", e.audio_bytes, a.audio_bytes);
            cmp("last_of_run", e.last_of_run, a.last_of_run);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_dsdcd_in  i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_dsdcd_out o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    dff_scoreboard sb;
    t_dsdcd_in     file_q[$];
    int            words_sent;
    bit            calm;

    dsd_container_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_word(o_out_word);
    end

    task automatic send_word(input t_dsdcd_in w);
        while (!calm && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_q[k]) send_word(file_q[k]);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_lsb_first(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.lsb_first = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic put_byte(input logic [7:0] b);
        t_dsdcd_in w;
        w.file_byte  = b;
        w.first_byte = 1'b0;
        w.final_byte = 1'b0;
        file_q.push_back(w);
    endtask

    task automatic put_n(input logic [63:0] v, input int n);
        for (int k = n - 1; k >= 0; k--) put_byte(v[8*k +: 8]);
    endtask

    task automatic patch_size(input int at, input logic [63:0] v);
        for (int k = 0; k < 8; k++) file_q[at + k].file_byte = v[8*(7-k) +: 8];
    endtask

    task automatic make_file(input logic [31:0] sr, input logic [15:0] ch,
                             input logic [63:0] dsd_size, input int supply,
                             input bit extras, input bit with_cmpr,
                             input logic [31:0] cmpr_type);
        int at;
        int start;
        int n;
        file_q.delete();
        put_n(ID_FRM8, 4);
        put_n({$urandom, $urandom}, 8);
        put_n(ID_DSD, 4);
        if (extras) begin
            n = $urandom_range(0, 3);
            put_n(32'h4142_4344, 4);
            put_n(n, 8);
            repeat (n) put_byte($urandom);
        end
        put_n(ID_PROP, 4);
        at = file_q.size();
        put_n(0, 8);
        start = file_q.size();
        put_n(ID_SND, 4);
        put_n(ID_FS, 4);
        put_n(4, 8);
        put_n(sr, 4);
        n = 2 + $urandom_range(0, 2);
        put_n(ID_CHNL, 4);
        put_n(n, 8);
        put_n(ch, 2);
        repeat (n - 2 + n % 2) put_byte($urandom);
        if (with_cmpr) begin
            n = 4 + $urandom_range(0, 3);
            put_n(ID_CMPR, 4);
            put_n(n, 8);
            put_n(cmpr_type, 4);
            repeat (n - 4 + n % 2) put_byte($urandom);
        end
        if (extras) begin
            n = $urandom_range(0, 3);
            put_n(32'h5859_5A57, 4);
            put_n(n, 8);
            repeat (n + n % 2) put_byte($urandom);
        end
        patch_size(at, file_q.size() - start);
        put_n(ID_DSD, 4);
        put_n(dsd_size, 8);
        repeat (supply) put_byte($urandom);
        file_q[0].first_byte = 1'b1;
        file_q[file_q.size() - 1].final_byte = 1'b1;
    endtask

    task automatic random_file();
        int          mode;
        int          pick;
        logic [31:0] sr;
        logic [15:0] ch;
        logic [31:0] ctype;
        logic [63:0] dsz;
        int          supply;
        t_dsdcd_in   w;
        mode  = $urandom_range(9);
        sr    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8, 300);
        ch    = $urandom_range(1, MAX_CHANNELS);
        ctype = ID_DSD;
        if (mode == 8) begin
            pick = $urandom_range(3);
            if (pick == 0) ch = $urandom_range(1) ? 16'd0 : $urandom_range(9, 65535);
            else if (pick == 1) sr = $urandom_range(0, 7);
            else ctype = $urandom;
        end
        dsz = (ch >= 1 && ch <= MAX_CHANNELS)
            ? ch * $urandom_range(0, 4) + $urandom_range(0, ch - 1) : $urandom_range(20);
        supply = dsz + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        make_file(sr, ch, dsz, supply, $urandom_range(1), mode == 8 || $urandom_range(9) < 7,
                  ctype);
        if (mode == 6) begin
            pick = $urandom_range(file_q.size() - 1);
            file_q[pick].file_byte ^= 8'd1 << $urandom_range(7);
        end else if (mode == 7) begin
            pick = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > pick) void'(file_q.pop_back());
            file_q[pick - 1].final_byte = 1'b1;
        end else if (mode == 9) begin
            file_q.delete();
            repeat ($urandom_range(1, 20)) begin
                w.file_byte  = $urandom;
                w.first_byte = ($urandom_range(9) == 0);
                w.final_byte = ($urandom_range(9) == 0);
                file_q.push_back(w);
            end
        end
        if (mode != 9) begin
            file_q[0].first_byte = ($urandom_range(9) != 0);
            file_q[file_q.size() - 1].final_byte = ($urandom_range(9) < 8);
        end
    endtask

    initial begin
        int nfiles;
        sb          = new();
        words_sent  = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_lsb_first(1'b0);
        file_q.delete();
        put_n(32'h4652_4D58, 4);
        file_q[0].first_byte = 1'b1;
        file_q[3].final_byte = 1'b1;
        send_file();
        calm = 1'b1;
        make_file(32'hFFFF_FFFF, MAX_CHANNELS, 16, 16, 1'b1, 1'b1, ID_DSD);
        send_file();
        calm = 1'b0;
        drain();
        write_lsb_first(1'b1);
        make_file(8, 1, 0, 0, 1'b0, 1'b0, ID_DSD);
        send_file();
        make_file(2822400, 2, 6, 6, 1'b0, 1'b1, 32'h5344_5832);
        send_file();
        make_file(2822400, 2, 64'hFFFF_FFFF_FFFF_FFFF, 3, 1'b0, 1'b0, ID_DSD);
        send_file();

        nfiles = 0;
        while (words_sent < 500) begin
            if (nfiles % 2 == 1) begin
                drain();
                write_lsb_first($urandom_range(1));
            end
            random_file();
            send_file();
            nfiles++;
        end

        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
